// ===== rtl/bmo_pkg.sv =====
`default_nettype none

package bmo_pkg;

    // Fixed geometry of the row words and of the stores.
    localparam int ROW_W       = 16;
    localparam int STORE_DEPTH = 16;
    localparam int DIM_W       = 5;
    localparam int IDX_W       = 4;
    localparam int CFG_IDX_W   = 2;

    // Input item function codes.
    localparam logic [1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [1:0] FUNC_RUN    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS  = 2'd3;

    typedef enum logic [1:0] {
        OP_MULTIPLY = 2'd0,
        OP_AND      = 2'd1,
        OP_OR       = 2'd2,
        OP_NOT_A    = 2'd3
    } op_mode_t;

    typedef struct packed {
        logic [1:0]       func;
        logic [IDX_W-1:0] row_index;
        logic [ROW_W-1:0] row_bits;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] result_row_index;
        logic [ROW_W-1:0] result_row_bits;
        logic             last;
    } out_item_t;

    // Control that travels alongside a row through the pipeline.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] index;
    } stage_ctrl_t;

    // A dimension of zero acts as one; one above the limit acts as the limit.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] limit);
        logic [DIM_W-1:0] r;
        begin
            if (v == '0) begin
                r = DIM_W'(1);
            end else if (v > limit) begin
                r = limit;
            end else begin
                r = v;
            end
            return r;
        end
    endfunction

    // Ones in the low cols bits; cols is at most ROW_W.
    function automatic logic [ROW_W-1:0] width_mask(input logic [DIM_W-1:0] cols);
        logic [ROW_W-1:0] m;
        begin
            m = ~({ROW_W{1'b1}} << cols);
            return m;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/boolean_matrix_ops.sv =====
`default_nettype none

// Channel     Direction  Handshake          Transaction payload
// s_          input      s_valid / s_ready  func, row_index, row_bits
// m_          output     m_valid / m_ready  result_row_index, result_row_bits, last
// cfg_        input      cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// A load transaction writes one row of A or B.
// A run transaction issues one row of A per cycle unless the pipeline stalls,
// so the effective row count sets its length; the input is taken again once
// the last row has left the fetch stage. Reset is synchronous, clears the
// control state and returns the configuration to multiply with sixteen rows
// and columns; the stores hold garbage until written.
// A held output row with m_ready low stalls the whole pipeline; no row is lost.
module boolean_matrix_ops #(
    parameter int MAX_DIM = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire bmo_pkg::in_item_t                   s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output bmo_pkg::out_item_t                       m_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [bmo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [bmo_pkg::DIM_W-1:0]           cfg_wdata
);

    // The number of usable rows is bounded both by the parameter and by the
    // fixed store depth. Each of these rows also has its own product lane.
    localparam int ROW_LIMIT = (MAX_DIM < bmo_pkg::STORE_DEPTH) ? MAX_DIM
                                                                : bmo_pkg::STORE_DEPTH;
    localparam int CNT_W     = $clog2(ROW_LIMIT);
    localparam logic [bmo_pkg::DIM_W-1:0] LIMIT_DIM = bmo_pkg::DIM_W'(ROW_LIMIT);

    // Configuration registers.
    bmo_pkg::op_mode_t          op_mode_reg;
    logic [bmo_pkg::DIM_W-1:0]  a_rows_reg;
    logic [bmo_pkg::DIM_W-1:0]  a_cols_reg;
    logic [bmo_pkg::DIM_W-1:0]  b_cols_reg;

    // Matrix stores, one row word per entry.
    logic [bmo_pkg::ROW_W-1:0]  a_store [ROW_LIMIT];
    logic [bmo_pkg::ROW_W-1:0]  b_store [ROW_LIMIT];

    // Issue stage state.
    logic                       busy_reg;
    logic [CNT_W-1:0]           cnt_reg;

    // Stage 1: fetched and masked rows of A and B.
    bmo_pkg::stage_ctrl_t       st1_ctrl_reg;
    logic [bmo_pkg::ROW_W-1:0]  st1_a_reg;
    logic [bmo_pkg::ROW_W-1:0]  st1_b_reg;

    // Stage 2: rows kept for the elementwise operations, lanes in parallel.
    bmo_pkg::stage_ctrl_t       st2_ctrl_reg;
    logic [bmo_pkg::ROW_W-1:0]  st2_a_reg;
    logic [bmo_pkg::ROW_W-1:0]  st2_b_reg;

    logic [ROW_LIMIT-1:0][bmo_pkg::ROW_W-1:0] lane_rows;

    logic [bmo_pkg::DIM_W-1:0]  rows_eff;
    logic [bmo_pkg::DIM_W-1:0]  acols_eff;
    logic [bmo_pkg::DIM_W-1:0]  bcols_eff;
    logic [bmo_pkg::ROW_W-1:0]  a_mask;
    logic [bmo_pkg::ROW_W-1:0]  b_mask;

    logic                       adv;
    logic                       s_accept;
    logic                       issue_last;
    logic                       m_valid_int;

    assign rows_eff  = bmo_pkg::eff_dim(a_rows_reg, LIMIT_DIM);
    assign acols_eff = bmo_pkg::eff_dim(a_cols_reg, LIMIT_DIM);
    assign bcols_eff = bmo_pkg::eff_dim(b_cols_reg, LIMIT_DIM);
    assign a_mask    = bmo_pkg::width_mask(acols_eff);
    assign b_mask    = bmo_pkg::width_mask(bcols_eff);

    // The pipeline moves whenever the output register is empty or being drained.
    assign adv = !m_valid_int || m_ready;

    // A new transaction waits until the previous run has left stage 1, since
    // the lanes still read the B store while its last row is in that stage.
    assign s_ready  = !busy_reg && !st1_ctrl_reg.valid;
    assign s_accept = s_valid && s_ready;

    assign issue_last = (bmo_pkg::DIM_W'(cnt_reg) + bmo_pkg::DIM_W'(1)) == rows_eff;

    // Configuration writes. All four indexes are listed; the default arm is never taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_mode_reg <= bmo_pkg::OP_MULTIPLY;
            a_rows_reg  <= bmo_pkg::DIM_W'(16);
            a_cols_reg  <= bmo_pkg::DIM_W'(16);
            b_cols_reg  <= bmo_pkg::DIM_W'(16);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bmo_pkg::CFG_OP_MODE: op_mode_reg <= bmo_pkg::op_mode_t'(cfg_wdata[1:0]);
                bmo_pkg::CFG_A_ROWS:  a_rows_reg  <= cfg_wdata;
                bmo_pkg::CFG_A_COLS:  a_cols_reg  <= cfg_wdata;
                bmo_pkg::CFG_B_COLS:  b_cols_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Row loads. A row index at or beyond the usable rows is ignored.
    always_ff @(posedge aclk) begin
        if (s_accept && ({1'b0, s_data.row_index} < LIMIT_DIM)) begin
            if (s_data.func == bmo_pkg::FUNC_LOAD_A) begin
                a_store[s_data.row_index[CNT_W-1:0]] <= s_data.row_bits;
            end else if (s_data.func == bmo_pkg::FUNC_LOAD_B) begin
                b_store[s_data.row_index[CNT_W-1:0]] <= s_data.row_bits;
            end
        end
    end

    // Issue control: a run transaction starts the row counter, which then steps
    // once per advancing cycle until the last row of A has been fetched.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            if (adv) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (issue_last) begin
                    busy_reg <= 1'b0;
                end
            end
        end else if (s_accept && s_data.func == bmo_pkg::FUNC_RUN) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
    end

    // Stage 1: fetch row i of both stores, masked to the columns of A.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_ctrl_reg.valid <= 1'b0;
        end else if (adv) begin
            st1_ctrl_reg.valid <= busy_reg;
            st1_ctrl_reg.last  <= issue_last;
            st1_ctrl_reg.index <= bmo_pkg::IDX_W'(cnt_reg);
            st1_a_reg          <= a_store[cnt_reg] & a_mask;
            st1_b_reg          <= b_store[cnt_reg] & a_mask;
        end
    end

    // Stage 2: the lanes form their partial products while the plain rows are
    // carried along for the elementwise operations.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_ctrl_reg.valid <= 1'b0;
        end else if (adv) begin
            st2_ctrl_reg.valid <= st1_ctrl_reg.valid;
            st2_ctrl_reg.last  <= st1_ctrl_reg.last;
            st2_ctrl_reg.index <= st1_ctrl_reg.index;
            st2_a_reg          <= st1_a_reg;
            st2_b_reg          <= st1_b_reg;
        end
    end

    // Lane k handles term k of the product: it passes row k of B when bit k of
    // the current A row is set. Bits of A beyond the columns are already clear.
    for (genvar k = 0; k < ROW_LIMIT; k++) begin : g_lane
        bmo_lane u_lane (
            .aclk     (aclk),
            .adv      (adv),
            .a_bit    (st1_a_reg[k]),
            .b_row    (b_store[k]),
            .b_mask   (b_mask),
            .prod_row (lane_rows[k])
        );
    end

    // Stage 3: merge the lanes or apply the elementwise operation, then hold
    // the result transaction until it is taken.
    bmo_merge #(
        .NUM_LANES (ROW_LIMIT)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .op_mode   (op_mode_reg),
        .a_mask    (a_mask),
        .ctrl      (st2_ctrl_reg),
        .a_row     (st2_a_reg),
        .b_row     (st2_b_reg),
        .lane_rows (lane_rows),
        .m_valid   (m_valid_int),
        .m_data    (m_data)
    );

    assign m_valid = m_valid_int;

endmodule

`default_nettype wire

// ===== rtl/bmo_lane.sv =====
`default_nettype none

// One product lane: contributes row k of B when bit k of the A row is set.
module bmo_lane (
    input  wire logic                     aclk,
    input  wire logic                     adv,
    input  wire logic                     a_bit,
    input  wire logic [bmo_pkg::ROW_W-1:0] b_row,
    input  wire logic [bmo_pkg::ROW_W-1:0] b_mask,
    output logic      [bmo_pkg::ROW_W-1:0] prod_row
);

    logic [bmo_pkg::ROW_W-1:0] prod_reg;
    logic [bmo_pkg::ROW_W-1:0] prod_next;

    always_comb begin
        prod_next = a_bit ? (b_row & b_mask) : '0;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
        end
    end

    assign prod_row = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/bmo_merge.sv =====
`default_nettype none

// Combines the lane products (multiply) or the two rows (elementwise
// operations) and holds the result in the output register.
module bmo_merge #(
    parameter int NUM_LANES = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  adv,
    input  wire bmo_pkg::op_mode_t                     op_mode,
    input  wire logic [bmo_pkg::ROW_W-1:0]             a_mask,
    input  wire bmo_pkg::stage_ctrl_t                  ctrl,
    input  wire logic [bmo_pkg::ROW_W-1:0]             a_row,
    input  wire logic [bmo_pkg::ROW_W-1:0]             b_row,
    input  wire logic [NUM_LANES-1:0][bmo_pkg::ROW_W-1:0] lane_rows,
    output logic                                       m_valid,
    output bmo_pkg::out_item_t                         m_data
);

    logic                      valid_reg;
    bmo_pkg::out_item_t        data_reg;
    logic [bmo_pkg::ROW_W-1:0] prod_or;
    logic [bmo_pkg::ROW_W-1:0] row_next;

    always_comb begin
        prod_or = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            prod_or = prod_or | lane_rows[k];
        end
        case (op_mode)
            bmo_pkg::OP_MULTIPLY: row_next = prod_or;
            bmo_pkg::OP_AND:      row_next = a_row & b_row;
            bmo_pkg::OP_OR:       row_next = a_row | b_row;
            bmo_pkg::OP_NOT_A:    row_next = ~a_row & a_mask;
            default:              row_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg.result_row_index <= ctrl.index;
            data_reg.result_row_bits  <= row_next;
            data_reg.last             <= ctrl.last;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire
